// ===== rtl/csr_sparse_slice_streamer_defines.svh =====
// Assertion macros shared by the csr_sparse_slice_streamer RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef CSR_SPARSE_SLICE_STREAMER_DEFINES_SVH
`define CSR_SPARSE_SLICE_STREAMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csrs: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csrs: next-cycle check failed");

`endif

// ===== rtl/csrs_pkg.sv =====
// Shared types and constants for the CSR slice streamer.
// No dependencies; used by every module of the block but csrs_queue.
package csrs_pkg;

    // Default parameter values.
    localparam int VALUE_BITS_DEF = 64;
    localparam int ROW_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF = 32;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_BATCH_FIRST    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BATCH_LIMIT    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROWS_PER_BATCH = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_FIRST      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_LIMIT      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_COL_FIRST      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_COL_LIMIT      = 3'd6;

    // Input operation codes and result kinds.
    localparam logic OP_ENTRY   = 1'b0;
    localparam logic OP_ROW_END = 1'b1;
    localparam logic KIND_COLUMN  = 1'b0;
    localparam logic KIND_POINTER = 1'b1;

    // Row compares are done at this width (covers ROW_BITS up to 32 plus carry).
    localparam int ROW_CMP_W = 33;

    // Field widths fixed by the stream format.
    localparam int COL_W = 32;
    localparam int PTR_W = 32;

    // Action queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Control part of a queued action.
    typedef struct packed {
        logic is_row;     // row pointer request, else column entry
        logic lead_zero;  // first kept row of a batch: zero pointer goes first
    } act_ctrl_t;

    localparam int ACT_CTRL_W = $bits(act_ctrl_t);

endpackage

// ===== rtl/csrs_queue.sv =====
// Small register FIFO carrying classified requests from front to back.
// No dependencies; sized by its WIDTH and DEPTH parameters, which the top sets.
module csrs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    logic do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/csrs_front.sv =====
// Front end: configuration registers, batch/row/count tracking and window
// classification of each input. Depends on csrs_pkg.
module csrs_front #(
    parameter int VALUE_BITS = csrs_pkg::VALUE_BITS_DEF,
    parameter int ROW_BITS   = csrs_pkg::ROW_BITS_DEF,
    parameter int COUNT_BITS = csrs_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_write,
    input  logic [csrs_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [csrs_pkg::CFG_DATA_W-1:0] cfg_data,
    // input request
    input  logic                            accept,
    input  logic                            operation,
    input  logic [csrs_pkg::COL_W-1:0]      column,
    input  logic [VALUE_BITS-1:0]           entry_value,
    // classified action toward the queue
    output logic                            act_valid,
    output csrs_pkg::act_ctrl_t             act_ctrl,
    output logic [csrs_pkg::PTR_W-1:0]      act_word,
    output logic [VALUE_BITS-1:0]           act_value
);

    localparam int RCW = csrs_pkg::ROW_CMP_W;

    // configuration registers
    logic [15:0] batch_first_reg;
    logic [16:0] batch_limit_reg;
    logic [16:0] rows_per_batch_reg;
    logic [15:0] row_first_reg;
    logic [16:0] row_limit_reg;
    logic [31:0] col_first_reg;
    logic [31:0] col_limit_reg;

    // tracking state
    logic [ROW_BITS-1:0]   row_counter_reg, row_counter_next;
    logic [15:0]           batch_counter_reg, batch_counter_next;
    logic [COUNT_BITS-1:0] kept_count_reg, kept_count_next;

    logic              batch_kept, row_kept, col_kept, entry_kept;
    logic              first_row;
    logic [ROW_BITS:0] row_inc;
    logic              row_wrap;

    always_comb
    begin
        batch_kept = ({1'b0, batch_counter_reg} >= {1'b0, batch_first_reg})
                  && ({1'b0, batch_counter_reg} < batch_limit_reg);
        row_kept   = (RCW'(row_counter_reg) >= RCW'(row_first_reg))
                  && (RCW'(row_counter_reg) < RCW'(row_limit_reg));
        first_row  = (RCW'(row_counter_reg) == RCW'(row_first_reg));
        col_kept   = (column >= col_first_reg) && (column < col_limit_reg);
        entry_kept = batch_kept && row_kept && col_kept;

        // row advance; wrap on rows_per_batch or on counter overflow
        row_inc  = {1'b0, row_counter_reg} + (ROW_BITS + 1)'(1);
        row_wrap = row_inc[ROW_BITS] || (RCW'(row_inc) >= RCW'(rows_per_batch_reg));

        row_counter_next   = row_counter_reg;
        batch_counter_next = batch_counter_reg;
        kept_count_next    = kept_count_reg;
        if (accept)
        begin
            if (operation == csrs_pkg::OP_ENTRY)
            begin
                if (entry_kept && (kept_count_reg != '1))
                begin
                    kept_count_next = kept_count_reg + COUNT_BITS'(1);
                end
            end
            else if (row_wrap)
            begin
                row_counter_next   = '0;
                batch_counter_next = batch_counter_reg + 16'd1;
                kept_count_next    = '0;
            end
            else
            begin
                row_counter_next = row_inc[ROW_BITS-1:0];
            end
        end

        act_valid = accept && ((operation == csrs_pkg::OP_ENTRY) ? entry_kept
                                                                 : (batch_kept && row_kept));
        act_ctrl.is_row    = (operation == csrs_pkg::OP_ROW_END);
        act_ctrl.lead_zero = (operation == csrs_pkg::OP_ROW_END) && first_row;
        act_word  = (operation == csrs_pkg::OP_ENTRY) ? (column - col_first_reg)
                                                      : csrs_pkg::PTR_W'(kept_count_reg);
        act_value = entry_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_first_reg    <= 16'd0;
            batch_limit_reg    <= 17'd1;
            rows_per_batch_reg <= 17'h10000;
            row_first_reg      <= 16'd0;
            row_limit_reg      <= 17'h10000;
            col_first_reg      <= 32'd0;
            col_limit_reg      <= 32'hFFFF_FFFF;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                csrs_pkg::REG_BATCH_FIRST:    batch_first_reg    <= cfg_data[15:0];
                csrs_pkg::REG_BATCH_LIMIT:    batch_limit_reg    <= cfg_data[16:0];
                csrs_pkg::REG_ROWS_PER_BATCH: rows_per_batch_reg <= cfg_data[16:0];
                csrs_pkg::REG_ROW_FIRST:      row_first_reg      <= cfg_data[15:0];
                csrs_pkg::REG_ROW_LIMIT:      row_limit_reg      <= cfg_data[16:0];
                csrs_pkg::REG_COL_FIRST:      col_first_reg      <= cfg_data;
                csrs_pkg::REG_COL_LIMIT:      col_limit_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_counter_reg   <= '0;
            batch_counter_reg <= '0;
            kept_count_reg    <= '0;
        end
        else
        begin
            row_counter_reg   <= row_counter_next;
            batch_counter_reg <= batch_counter_next;
            kept_count_reg    <= kept_count_next;
        end
    end

endmodule

// ===== rtl/csrs_back.sv =====
// Back end: expands queued actions into one or two results and holds the
// result register. Depends on csrs_pkg and the shared assertion macros.
`include "csr_sparse_slice_streamer_defines.svh"

module csrs_back #(
    parameter int VALUE_BITS = csrs_pkg::VALUE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // queue head
    input  logic                       q_empty,
    input  csrs_pkg::act_ctrl_t        q_ctrl,
    input  logic [csrs_pkg::PTR_W-1:0] q_word,
    input  logic [VALUE_BITS-1:0]      q_value,
    output logic                       q_pop,
    // result side
    input  logic                       pop,
    output logic                       empty,
    output logic                       kind,
    output logic [csrs_pkg::COL_W-1:0] shifted_column,
    output logic [VALUE_BITS-1:0]      kept_value,
    output logic [csrs_pkg::PTR_W-1:0] row_pointer,
    output logic                       last_of_run
);

    logic                       valid_reg, valid_next;
    logic                       phase_reg, phase_next;   // leading zero sent
    logic                       kind_reg, kind_next;
    logic [csrs_pkg::COL_W-1:0] col_reg, col_next;
    logic [VALUE_BITS-1:0]      val_reg, val_next;
    logic [csrs_pkg::PTR_W-1:0] ptr_reg, ptr_next;
    logic                       last_reg, last_next;
    logic                       load;
    logic                       zero_held;

    always_comb
    begin
        load       = !valid_reg || pop;
        q_pop      = 1'b0;
        valid_next = valid_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        col_next   = col_reg;
        val_next   = val_reg;
        ptr_next   = ptr_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = !q_empty;
            if (!q_empty)
            begin
                if (q_ctrl.lead_zero && !phase_reg)
                begin
                    // zero pointer ahead of the batch's first kept row
                    phase_next = 1'b1;
                    kind_next  = csrs_pkg::KIND_POINTER;
                    col_next   = '0;
                    val_next   = '0;
                    ptr_next   = '0;
                    last_next  = 1'b0;
                end
                else
                begin
                    q_pop      = 1'b1;
                    phase_next = 1'b0;
                    last_next  = 1'b1;
                    if (q_ctrl.is_row)
                    begin
                        kind_next = csrs_pkg::KIND_POINTER;
                        col_next  = '0;
                        val_next  = '0;
                        ptr_next  = q_word;
                    end
                    else
                    begin
                        kind_next = csrs_pkg::KIND_COLUMN;
                        col_next  = q_word;
                        val_next  = q_value;
                        ptr_next  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        col_reg  <= col_next;
        val_reg  <= val_next;
        ptr_reg  <= ptr_next;
        last_reg <= last_next;
    end

    assign empty          = !valid_reg;
    assign kind           = kind_reg;
    assign shifted_column = col_reg;
    assign kept_value     = val_reg;
    assign row_pointer    = ptr_reg;
    assign last_of_run    = last_reg;

    // result register currently holds a leading zero pointer
    assign zero_held = valid_reg && (kind_reg == csrs_pkg::KIND_POINTER) && !last_reg
                    && (ptr_reg == '0);

    // After the leading zero goes out, it waits in the result register.
    `CSRS_ASSERT_IMP(a_phase_holds_zero, clk, rst_n, phase_reg, zero_held)
    // The action that caused the leading zero stays at the queue head.
    `CSRS_ASSERT_IMP(a_phase_head, clk, rst_n, phase_reg, !q_empty && q_ctrl.lead_zero && q_ctrl.is_row)
    // Column entries always close their run.
    `CSRS_ASSERT_IMP(a_column_last, clk, rst_n, valid_reg && (kind_reg == csrs_pkg::KIND_COLUMN), last_reg)
    // A popped queue entry always produces a final result.
    `CSRS_ASSERT_NXT(a_pop_final, clk, rst_n, q_pop, valid_reg && last_reg && !phase_reg)

endmodule

// ===== rtl/csr_sparse_slice_streamer.sv =====
// Top level of the CSR slice streamer: front classifier, action queue and
// back expander. Depends on csrs_pkg, csrs_front, csrs_queue, csrs_back.
//
// Usage:
//   Input channel: push / full. A request (operation, column, entry_value)
//   is taken at a clock edge with push high and full low. operation 0 is a
//   nonzero entry, 1 closes the current row.
//   Result channel: empty / pop. While empty is low the oldest result sits
//   on kind, shifted_column, kept_value, row_pointer, last_of_run; it is
//   taken at an edge with pop high and empty low.
//   Configuration: cfg_write / cfg_index / cfg_data, one register per edge.
//   The user writes only while the block is drained; the block does not
//   enforce it. A kept request is written to the action queue at the
//   accepting edge, then loaded into the result register when that is
//   empty or being popped. Throughput: one request per cycle on the input
//   while full is low; one result per cycle while pop is high. A row end
//   that opens a batch's kept rows gives two results (leading zero pointer
//   plus pointer). The four-entry action queue absorbs that and short
//   receiver stalls; a longer stall fills it, full rises and requests wait
//   until the receiver pops again. Full rises only when the queue is full.
//   Reset: config returns to its defaults, counters clear, queue and the
//   result register empty.
module csr_sparse_slice_streamer #(
    parameter int VALUE_BITS = csrs_pkg::VALUE_BITS_DEF,
    parameter int ROW_BITS   = csrs_pkg::ROW_BITS_DEF,
    parameter int COUNT_BITS = csrs_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_write,
    input  logic [csrs_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [csrs_pkg::CFG_DATA_W-1:0] cfg_data,
    // input requests
    input  logic                            push,
    output logic                            full,
    input  logic                            operation,
    input  logic [csrs_pkg::COL_W-1:0]      column,
    input  logic [VALUE_BITS-1:0]           entry_value,
    // results
    input  logic                            pop,
    output logic                            empty,
    output logic                            kind,
    output logic [csrs_pkg::COL_W-1:0]      shifted_column,
    output logic [VALUE_BITS-1:0]           kept_value,
    output logic [csrs_pkg::PTR_W-1:0]      row_pointer,
    output logic                            last_of_run
);

    localparam int QW = csrs_pkg::ACT_CTRL_W + csrs_pkg::PTR_W + VALUE_BITS;

    logic                       accept;
    logic                       act_valid;
    csrs_pkg::act_ctrl_t        act_ctrl;
    logic [csrs_pkg::PTR_W-1:0] act_word;
    logic [VALUE_BITS-1:0]      act_value;

    logic [QW-1:0]              q_head;
    logic                       q_empty;
    logic                       q_pop;
    csrs_pkg::act_ctrl_t        q_ctrl;
    logic [csrs_pkg::PTR_W-1:0] q_word;
    logic [VALUE_BITS-1:0]      q_value;

    // a request is consumed whenever the queue has room, kept or not
    assign accept = push && !full;

    csrs_front #(
        .VALUE_BITS (VALUE_BITS),
        .ROW_BITS   (ROW_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .operation   (operation),
        .column      (column),
        .entry_value (entry_value),
        .act_valid   (act_valid),
        .act_ctrl    (act_ctrl),
        .act_word    (act_word),
        .act_value   (act_value)
    );

    csrs_queue #(
        .WIDTH (QW),
        .DEPTH (csrs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (act_valid),
        .wr_data ({act_ctrl, act_word, act_value}),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    assign q_ctrl  = csrs_pkg::act_ctrl_t'(q_head[QW-1 -: csrs_pkg::ACT_CTRL_W]);
    assign q_word  = q_head[VALUE_BITS +: csrs_pkg::PTR_W];
    assign q_value = q_head[VALUE_BITS-1:0];

    csrs_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_ctrl         (q_ctrl),
        .q_word         (q_word),
        .q_value        (q_value),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .kind           (kind),
        .shifted_column (shifted_column),
        .kept_value     (kept_value),
        .row_pointer    (row_pointer),
        .last_of_run    (last_of_run)
    );

endmodule

// ===== dv/csr_sparse_slice_streamer_checker.sv =====
// Scoreboard for csr_sparse_slice_streamer: mirrors the window registers and
// the row/batch/count state, predicts each result and compares in order.
// Depends on csrs_pkg.
`timescale 1ns / 1ps

module csr_sparse_slice_streamer_checker #(
    parameter int VALUE_BITS = csrs_pkg::VALUE_BITS_DEF,
    parameter int ROW_BITS   = csrs_pkg::ROW_BITS_DEF,
    parameter int COUNT_BITS = csrs_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [csrs_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [csrs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            push,
    input  logic                            full,
    input  logic                            operation,
    input  logic [csrs_pkg::COL_W-1:0]      column,
    input  logic [VALUE_BITS-1:0]           entry_value,
    input  logic                            pop,
    input  logic                            empty,
    input  logic                            kind,
    input  logic [csrs_pkg::COL_W-1:0]      shifted_column,
    input  logic [VALUE_BITS-1:0]           kept_value,
    input  logic [csrs_pkg::PTR_W-1:0]      row_pointer,
    input  logic                            last_of_run,
    output int                              errors,
    output int                              pending
);

    localparam int RCW = csrs_pkg::ROW_CMP_W;

    typedef struct packed {
        logic                       kind;
        logic [csrs_pkg::COL_W-1:0] col;
        logic [VALUE_BITS-1:0]      val;
        logic [csrs_pkg::PTR_W-1:0] ptr;
        logic                       last;
    } slice_result_t;

    // window registers
    logic [15:0]                win_batch_first;
    logic [16:0]                win_batch_limit;
    logic [16:0]                win_rows_per_batch;
    logic [15:0]                win_row_first;
    logic [16:0]                win_row_limit;
    logic [csrs_pkg::COL_W-1:0] win_col_first;
    logic [csrs_pkg::COL_W-1:0] win_col_limit;

    // stream position
    logic [ROW_BITS-1:0]   row_idx;
    logic [15:0]           batch_idx;
    logic [COUNT_BITS-1:0] kept_total;

    slice_result_t awaited[$];
    slice_result_t want;

    function automatic slice_result_t make_result(input logic k,
                                                  input logic [csrs_pkg::COL_W-1:0] c,
                                                  input logic [VALUE_BITS-1:0] v,
                                                  input logic [csrs_pkg::PTR_W-1:0] p,
                                                  input logic l);
        slice_result_t res;
        res.kind = k;
        res.col  = c;
        res.val  = v;
        res.ptr  = p;
        res.last = l;
        return res;
    endfunction

    task automatic predict_request(input logic op, input logic [csrs_pkg::COL_W-1:0] col,
                                   input logic [VALUE_BITS-1:0] val);
        logic                       batch_hit;
        logic                       row_hit;
        logic                       col_hit;
        logic [ROW_BITS:0]          next_row;
        logic [csrs_pkg::PTR_W-1:0] ptr_now;
        batch_hit = ({1'b0, batch_idx} >= {1'b0, win_batch_first})
                 && ({1'b0, batch_idx} < win_batch_limit);
        row_hit   = (RCW'(row_idx) >= RCW'(win_row_first))
                 && (RCW'(row_idx) < RCW'(win_row_limit));
        col_hit   = (col >= win_col_first) && (col < win_col_limit);
        if (op == csrs_pkg::OP_ENTRY)
        begin
            if (batch_hit && row_hit && col_hit)
            begin
                awaited.push_back(make_result(csrs_pkg::KIND_COLUMN, col - win_col_first,
                                              val, '0, 1'b1));
                if (kept_total != '1)
                begin
                    kept_total = kept_total + COUNT_BITS'(1);
                end
            end
        end
        else
        begin
            if (batch_hit && row_hit)
            begin
                // first kept row of the batch opens with a zero pointer
                if (RCW'(row_idx) == RCW'(win_row_first))
                begin
                    awaited.push_back(make_result(csrs_pkg::KIND_POINTER, '0, '0, '0, 1'b0));
                end
                ptr_now = csrs_pkg::PTR_W'(kept_total);
                awaited.push_back(make_result(csrs_pkg::KIND_POINTER, '0, '0, ptr_now, 1'b1));
            end
            next_row = {1'b0, row_idx} + (ROW_BITS + 1)'(1);
            if ((RCW'(next_row) >= RCW'(win_rows_per_batch)) || next_row[ROW_BITS])
            begin
                row_idx    = '0;
                batch_idx  = batch_idx + 16'd1;
                kept_total = '0;
            end
            else
            begin
                row_idx = next_row[ROW_BITS-1:0];
            end
        end
    endtask

    task automatic note_error(input bit have_want, input slice_result_t exp_res);
        errors++;
        if (errors <= 10)
        begin
            if (!have_want)
            begin
                $display("%0t: result with nothing awaited", $time);
                $display("  actual   kind=%0d col=%h val=%h ptr=%h last=%0d",
                         kind, shifted_column, kept_value, row_pointer, last_of_run);
            end
            else
            begin
                $display("%0t: result mismatch", $time);
                $display("  expected kind=%0d col=%h val=%h ptr=%h last=%0d",
                         exp_res.kind, exp_res.col, exp_res.val, exp_res.ptr, exp_res.last);
                $display("  actual   kind=%0d col=%h val=%h ptr=%h last=%0d",
                         kind, shifted_column, kept_value, row_pointer, last_of_run);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_batch_first    = '0;
            win_batch_limit    = 17'd1;
            win_rows_per_batch = 17'd65536;
            win_row_first      = '0;
            win_row_limit      = 17'd65536;
            win_col_first      = '0;
            win_col_limit      = '1;
            row_idx            = '0;
            batch_idx          = '0;
            kept_total         = '0;
            awaited.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    csrs_pkg::REG_BATCH_FIRST:    win_batch_first    = cfg_data[15:0];
                    csrs_pkg::REG_BATCH_LIMIT:    win_batch_limit    = cfg_data[16:0];
                    csrs_pkg::REG_ROWS_PER_BATCH: win_rows_per_batch = cfg_data[16:0];
                    csrs_pkg::REG_ROW_FIRST:      win_row_first      = cfg_data[15:0];
                    csrs_pkg::REG_ROW_LIMIT:      win_row_limit      = cfg_data[16:0];
                    csrs_pkg::REG_COL_FIRST:      win_col_first      = cfg_data;
                    csrs_pkg::REG_COL_LIMIT:      win_col_limit      = cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                if (awaited.size() == 0)
                begin
                    note_error(1'b0, '0);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (kind !== want.kind || shifted_column !== want.col
                        || kept_value !== want.val || row_pointer !== want.ptr
                        || last_of_run !== want.last)
                    begin
                        note_error(1'b1, want);
                    end
                end
            end
            if (push && !full)
            begin
                predict_request(operation, column, entry_value);
            end
        end
        pending = awaited.size();
    end

endmodule

// ===== dv/csr_sparse_slice_streamer_tb.sv =====
// Top of the csr_sparse_slice_streamer testbench: clock, reset, window setup
// and request stimulus; the checker module scores the results.
// Depends on csrs_pkg, csr_sparse_slice_streamer, csr_sparse_slice_streamer_checker.
`timescale 1ns / 1ps

module csr_sparse_slice_streamer_tb;

    // Index past the register list; the block must ignore writes to it.
    localparam logic [csrs_pkg::CFG_ADDR_W-1:0] REG_SPARE = 3'd7;
    localparam int ROW_MAX     = (1 << csrs_pkg::ROW_BITS_DEF) - 1;
    localparam int BATCH_MAX   = 65535;
    localparam int CYCLE_LIMIT = 1500000;

    logic                                clk         = 1'b0;
    logic                                rst_n       = 1'b0;
    logic                                cfg_write   = 1'b0;
    logic [csrs_pkg::CFG_ADDR_W-1:0]     cfg_index   = '0;
    logic [csrs_pkg::CFG_DATA_W-1:0]     cfg_data    = '0;
    logic                                push        = 1'b0;
    logic                                full;
    logic                                operation   = 1'b0;
    logic [csrs_pkg::COL_W-1:0]          column      = '0;
    logic [csrs_pkg::VALUE_BITS_DEF-1:0] entry_value = '0;
    logic                                pop         = 1'b0;
    logic                                empty;
    logic                                kind;
    logic [csrs_pkg::COL_W-1:0]          shifted_column;
    logic [csrs_pkg::VALUE_BITS_DEF-1:0] kept_value;
    logic [csrs_pkg::PTR_W-1:0]          row_pointer;
    logic                                last_of_run;
    int                                  errors;
    int                                  pending;

    // Stimulus-side bookkeeping. The row and batch position is tracked only
    // so that batch windows can be placed where the stream currently is.
    int                         sent           = 0;
    int                         row_pos        = 0;
    int                         batch_pos      = 0;
    int                         stim_rpb       = 65536;
    logic [csrs_pkg::COL_W-1:0] stim_col_first = '0;
    logic [csrs_pkg::COL_W-1:0] stim_col_limit = '1;
    bit                         steady         = 1'b0;   // no idling on either side
    int                         cycles         = 0;

    csr_sparse_slice_streamer u_top (.*);

    csr_sparse_slice_streamer_checker u_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("csr_sparse_slice_streamer_tb: errors");
            $finish;
        end
    end

    // Sender idle length: mostly back to back, some short gaps, a few long.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(99);
        if (steady || r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [csrs_pkg::VALUE_BITS_DEF-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Columns cluster in the current window and on its edges, with some
    // fully random ones so every column bit toggles.
    function automatic logic [csrs_pkg::COL_W-1:0] pick_column();
        int                         r;
        logic [csrs_pkg::COL_W-1:0] span;
        r    = $urandom_range(99);
        span = stim_col_limit - stim_col_first;
        if (r < 50)
            return (stim_col_limit > stim_col_first) ? stim_col_first + ($urandom % span)
                                                     : $urandom;
        if (r < 60)
            return stim_col_first;
        if (r < 70)
            return stim_col_limit - 1'b1;
        if (r < 78)
            return stim_col_limit;
        if (r < 85)
            return stim_col_first - 1'b1;
        return $urandom;
    endfunction

    // Result side: pop in runs, stalls mostly short and sometimes long.
    // Long runs give stretches with no stalling at all.
    initial
    begin : pop_driver
        int run;
        int stall;
        int r;
        @(posedge clk);
        forever
        begin
            run = ($urandom_range(9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            r   = $urandom_range(99);
            if (r < 60)
                stall = $urandom_range(1, 3);
            else if (r < 90)
                stall = $urandom_range(4, 8);
            else
                stall = $urandom_range(20, 60);
            pop <= 1'b1;
            repeat (run) @(posedge clk);
            if (!steady)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // One request; returns after the edge where it was taken and any idle gap
    // after it. push stays high when the next request follows back to back.
    task automatic send_request(input logic op, input logic [csrs_pkg::COL_W-1:0] col,
                                input logic [csrs_pkg::VALUE_BITS_DEF-1:0] val);
        int idle;
        operation   <= op;
        column      <= col;
        entry_value <= val;
        push        <= 1'b1;
        do
            @(posedge clk);
        while (full);
        sent++;
        if (op == csrs_pkg::OP_ROW_END)
        begin
            if (row_pos + 1 >= stim_rpb || row_pos + 1 > ROW_MAX)
            begin
                row_pos   = 0;
                batch_pos = (batch_pos + 1) % (BATCH_MAX + 1);
            end
            else
            begin
                row_pos++;
            end
        end
        idle = pick_idle();
        if (idle > 0)
        begin
            push <= 1'b0;
            repeat (idle) @(posedge clk);
        end
    endtask

    // Wait until every awaited result is out, then let a row end that made
    // no result work its way through before the block is touched.
    task automatic settle();
        push <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [csrs_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [csrs_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Full window setup on a drained block; the spare index gets junk each time.
    task automatic set_windows(input int bf, input int bl, input int rpb, input int rf,
                               input int rl, input logic [csrs_pkg::COL_W-1:0] cf,
                               input logic [csrs_pkg::COL_W-1:0] cl);
        settle();
        write_reg(csrs_pkg::REG_BATCH_FIRST, bf & 'hFFFF);
        write_reg(csrs_pkg::REG_BATCH_LIMIT, bl & 'h1FFFF);
        write_reg(csrs_pkg::REG_ROWS_PER_BATCH, rpb & 'h1FFFF);
        write_reg(csrs_pkg::REG_ROW_FIRST, rf & 'hFFFF);
        write_reg(csrs_pkg::REG_ROW_LIMIT, rl & 'h1FFFF);
        write_reg(csrs_pkg::REG_COL_FIRST, cf);
        write_reg(csrs_pkg::REG_COL_LIMIT, cl);
        write_reg(REG_SPARE, $urandom);
        cfg_write      <= 1'b0;
        stim_rpb       = rpb & 'h1FFFF;
        stim_col_first = cf;
        stim_col_limit = cl;
    endtask

    // Random windows near the current batch, then whole rows of entries.
    task automatic random_phase();
        int                         r;
        int                         rpb;
        int                         rf;
        int                         rl;
        int                         bf;
        int                         bl;
        int                         n_items;
        int                         start;
        logic [csrs_pkg::COL_W-1:0] cf;
        logic [csrs_pkg::COL_W-1:0] cl;
        r = $urandom_range(99);
        if (r < 15)
            rpb = 0;
        else if (r < 30)
            rpb = 1;
        else if (r < 80)
            rpb = $urandom_range(2, 6);
        else if (r < 90)
            rpb = 65536;
        else
            rpb = $urandom_range(7, 20);

        r  = $urandom_range(99);
        rf = $urandom_range(0, 4);
        if (r < 15)
            rl = $urandom_range(0, rf);          // empty row window
        else if (r < 25)
        begin
            rf = 0;
            rl = 65536;
        end
        else
            rl = rf + $urandom_range(1, 3);

        r = $urandom_range(99);
        if (r < 20)
        begin
            bf = 0;
            bl = 65536;
        end
        else if (r < 28)
        begin
            bf = batch_pos;
            bl = 0;                              // no batch kept
        end
        else
        begin
            bf = (batch_pos + $urandom_range(0, 2)) % (BATCH_MAX + 1);
            bl = bf + $urandom_range(0, 4);
        end

        r = $urandom_range(99);
        if (r < 40)
        begin
            cf = $urandom_range(0, 50);
            cl = cf + $urandom_range(0, 60);
        end
        else if (r < 55)
        begin
            cf = '0;
            cl = '1;
        end
        else if (r < 62)
        begin
            cf = '0;
            cl = '0;
        end
        else if (r < 80)
        begin
            cf = $urandom;
            cl = $urandom;
        end
        else
        begin
            cf = $urandom;
            cl = cf + $urandom_range(1, 100);
        end

        steady = ($urandom_range(3) == 0);
        set_windows(bf, bl, rpb, rf, rl, cf, cl);
        n_items = $urandom_range(40, 100);
        start   = sent;
        while (sent - start < n_items)
        begin
            repeat ($urandom_range(0, 5))
                send_request(csrs_pkg::OP_ENTRY, pick_column(), pick_value());
            // payload of a row end is don't-care; randomize it anyway
            send_request(csrs_pkg::OP_ROW_END, $urandom, pick_value());
        end
    endtask

    initial
    begin : stimulus
        int random_start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset windows: batch 0 only, all rows, columns below all-ones.
        send_request(csrs_pkg::OP_ENTRY, '0, '0);
        send_request(csrs_pkg::OP_ENTRY, 32'hFFFF_FFFE, '1);
        send_request(csrs_pkg::OP_ENTRY, 32'hFFFF_FFFF, pick_value()); // limit is exclusive
        send_request(csrs_pkg::OP_ROW_END, '0, '0);                    // zero pointer, then 2
        send_request(csrs_pkg::OP_ENTRY, $urandom, pick_value());
        send_request(csrs_pkg::OP_ROW_END, '1, '1);                    // pointer only

        // Two-row batches, only row 1 kept, columns 16..31 shifted down by 16.
        set_windows(batch_pos, batch_pos + 2, 2, 1, 2, 32'd16, 32'd32);
        send_request(csrs_pkg::OP_ROW_END, '0, '0);                    // row 2 closes the batch
        send_request(csrs_pkg::OP_ENTRY, 32'd16, pick_value());        // row 0 is outside
        send_request(csrs_pkg::OP_ROW_END, '0, '0);
        send_request(csrs_pkg::OP_ENTRY, 32'd15, pick_value());
        send_request(csrs_pkg::OP_ENTRY, 32'd16, pick_value());
        send_request(csrs_pkg::OP_ENTRY, 32'd31, pick_value());
        send_request(csrs_pkg::OP_ENTRY, 32'd32, pick_value());
        send_request(csrs_pkg::OP_ROW_END, '0, '0);
        send_request(csrs_pkg::OP_ENTRY, 32'd16, pick_value());        // batch past the window
        send_request(csrs_pkg::OP_ROW_END, '0, '0);

        // Zero rows per batch: each row is a batch of its own, count restarts.
        set_windows(0, 65536, 0, 0, 1, '0, '1);
        send_request(csrs_pkg::OP_ENTRY, $urandom, pick_value());
        send_request(csrs_pkg::OP_ENTRY, $urandom, pick_value());
        send_request(csrs_pkg::OP_ROW_END, '0, '0);
        send_request(csrs_pkg::OP_ROW_END, '0, '0);

        // Empty row window: nothing at all comes out.
        set_windows(0, 65536, 3, 2, 2, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(csrs_pkg::OP_ENTRY, 32'hFFFF_FFFE, pick_value());
        send_request(csrs_pkg::OP_ROW_END, '0, '0);
        send_request(csrs_pkg::OP_ROW_END, '0, '0);

        random_start = sent;
        while (sent - random_start < 800)
            random_phase();

        // Drain, then keep popping long enough to catch any stray result.
        push <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        steady = 1'b1;
        repeat (80) @(posedge clk);
        if (errors == 0)
            $display("csr_sparse_slice_streamer_tb: clean");
        else
            $display("csr_sparse_slice_streamer_tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/csrs_pkg.sv
rtl/csrs_queue.sv
rtl/csrs_front.sv
rtl/csrs_back.sv
rtl/csr_sparse_slice_streamer.sv
dv/csr_sparse_slice_streamer_checker.sv
dv/csr_sparse_slice_streamer_tb.sv
